@@ hw/rtl/lfu_pkg.sv @@
// shared types and constants for the lfu cache with lru tiebreak
package lfu_pkg;

  // built number of entries and derived widths
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned AGE_W   = $clog2(ENTRIES);
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned WORD_W  = 32;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [WORD_W-1:0] MISS_VALUE = '1;
  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(ENTRIES);

  // request operation codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;

endpackage

@@ hw/rtl/lfu_cache_with_lru_tiebreak.sv @@
// top level of the lfu cache with lru tiebreak, one shared scan unit
//
//   port group   dir   handshake                   word
//   in_*         in    in_valid_i / in_ready_o     lfu_pkg::req_t (func, key, write_value)
//   out_*        out   out_valid_o / out_ready_i   lfu_pkg::rsp_t (found, read_value, ...)
//   cfg_*        in    cfg_valid_i / cfg_ready_o   capacity, 5 bits
//
// a request is accepted in the idle state, then scanned one entry a cycle through
// the shared key/victim compare unit, then passes a decide state and a response state;
// a get miss goes straight from decide to response; every other request adds an update
// pass over the recency ranks, one entry a cycle, before the response
// reset empties the cache (valid bits and occupancy cleared), capacity goes to 16
// a waiting response does not block the next request; the response cycle
// holds only if the output register is still full
module lfu_cache_with_lru_tiebreak (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lfu_pkg::req_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfu_pkg::rsp_t                 out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfu_pkg::CAP_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESP
  } state_e;

  localparam logic [lfu_pkg::IDX_W-1:0] LAST_IDX = lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1);

  // entry store: valid bits reset, payload undefined until written
  logic [lfu_pkg::ENTRIES-1:0]    valid_q;
  logic [lfu_pkg::WORD_W-1:0]     key_q   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::WORD_W-1:0]     value_q [lfu_pkg::ENTRIES];
  logic [lfu_pkg::CNT_W-1:0]      cnt_q   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::AGE_W-1:0]      age_q   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::OCC_W-1:0]      occ_q;
  logic [lfu_pkg::CAP_W-1:0]      capacity_q;

  // sequencer and request context
  state_e                         state_q;
  logic [lfu_pkg::IDX_W-1:0]      idx_q;
  lfu_pkg::req_t                  req_q;

  // scan results
  logic                           hit_q;
  logic [lfu_pkg::IDX_W-1:0]      hit_idx_q;
  logic [lfu_pkg::AGE_W-1:0]      hit_age_q;
  logic [lfu_pkg::WORD_W-1:0]     hit_value_q;
  logic                           free_found_q;
  logic [lfu_pkg::IDX_W-1:0]      free_idx_q;
  logic                           have_q;
  logic [lfu_pkg::IDX_W-1:0]      vic_idx_q;
  logic [lfu_pkg::AGE_W-1:0]      vic_age_q;
  logic [lfu_pkg::CNT_W-1:0]      vic_cnt_q;
  logic [lfu_pkg::WORD_W-1:0]     vic_key_q;

  // decided action
  logic                           evict_q;
  logic [lfu_pkg::IDX_W-1:0]      ins_idx_q;
  lfu_pkg::rsp_t                  rsp_q;

  // output register
  logic                           out_valid_q;
  lfu_pkg::rsp_t                  out_rsp_q;

  // entry under the shared unit
  logic                           cur_valid;
  logic [lfu_pkg::WORD_W-1:0]     cur_key;
  logic [lfu_pkg::WORD_W-1:0]     cur_value;
  logic [lfu_pkg::CNT_W-1:0]      cur_cnt;
  logic [lfu_pkg::AGE_W-1:0]      cur_age;
  logic                           key_match;
  logic                           better;
  logic [lfu_pkg::CAP_W-1:0]      cap_eff;
  logic                           need_evict;
  logic                           at_idx_ins;
  logic                           at_idx_vic;

  assign cur_valid = valid_q[idx_q];
  assign cur_key   = key_q[idx_q];
  assign cur_value = value_q[idx_q];
  assign cur_cnt   = cnt_q[idx_q];
  assign cur_age   = age_q[idx_q];

  // shared compare unit: key match and victim order (lowest count, then oldest)
  assign key_match = cur_valid && (cur_key == req_q.key);
  assign better    = !have_q || (cur_cnt < vic_cnt_q) ||
                     ((cur_cnt == vic_cnt_q) && (cur_age > vic_age_q));

  // zero acts as one, oversized as the built size
  always_comb begin
    cap_eff = capacity_q;
    if (capacity_q == '0) begin
      cap_eff = lfu_pkg::CAP_W'(1);
    end else if (capacity_q > lfu_pkg::CAP_W'(lfu_pkg::ENTRIES)) begin
      cap_eff = lfu_pkg::CAP_W'(lfu_pkg::ENTRIES);
    end
  end

  assign need_evict = lfu_pkg::CAP_W'(occ_q) >= cap_eff;
  assign at_idx_ins = idx_q == ins_idx_q;
  assign at_idx_vic = evict_q && (idx_q == vic_idx_q);

  assign in_ready_o  = state_q == ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // sequencer, control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      valid_q      <= '0;
      occ_q        <= '0;
      capacity_q   <= lfu_pkg::CAP_RESET;
      req_q        <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_age_q    <= '0;
      hit_value_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      have_q       <= 1'b0;
      vic_idx_q    <= '0;
      vic_age_q    <= '0;
      vic_cnt_q    <= '0;
      vic_key_q    <= '0;
      evict_q      <= 1'b0;
      ins_idx_q    <= '0;
      rsp_q        <= '0;
      out_valid_q  <= 1'b0;
      out_rsp_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      // in the response state the new word takes the freed register itself
      if (out_valid_q && out_ready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q        <= in_req_i;
            idx_q        <= '0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            have_q       <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // first matching entry wins
          if (key_match && !hit_q) begin
            hit_q       <= 1'b1;
            hit_idx_q   <= idx_q;
            hit_age_q   <= cur_age;
            hit_value_q <= cur_value;
          end
          if (!cur_valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (cur_valid && better) begin
            have_q    <= 1'b1;
            vic_idx_q <= idx_q;
            vic_age_q <= cur_age;
            vic_cnt_q <= cur_cnt;
            vic_key_q <= cur_key;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == LAST_IDX) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          idx_q       <= '0;
          rsp_q.found <= hit_q;
          evict_q     <= 1'b0;
          if (req_q.func == lfu_pkg::FUNC_GET) begin
            rsp_q.read_value  <= hit_q ? hit_value_q : lfu_pkg::MISS_VALUE;
            rsp_q.evicted     <= 1'b0;
            rsp_q.evicted_key <= '0;
            state_q           <= hit_q ? ST_UPDATE : ST_RESP;
          end else begin
            rsp_q.read_value <= '0;
            if (hit_q) begin
              rsp_q.evicted     <= 1'b0;
              rsp_q.evicted_key <= '0;
            end else begin
              evict_q           <= need_evict;
              rsp_q.evicted     <= need_evict;
              rsp_q.evicted_key <= need_evict ? vic_key_q : '0;
              // new key lands in the lowest free slot after any removal
              if (need_evict && (!free_found_q || (vic_idx_q < free_idx_q))) begin
                ins_idx_q <= vic_idx_q;
              end else begin
                ins_idx_q <= free_idx_q;
              end
            end
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (!hit_q) begin
            if (at_idx_ins) begin
              valid_q[idx_q] <= 1'b1;
            end else if (at_idx_vic) begin
              valid_q[idx_q] <= 1'b0;
            end
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == LAST_IDX) begin
            if (!hit_q && !evict_q) begin
              occ_q <= occ_q + 1'b1;
            end
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_rsp_q   <= rsp_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // entry payload, one entry a cycle during the update pass
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      if (hit_q) begin
        // touch: raise count, make most recent, shift younger ranks down
        if (idx_q == hit_idx_q) begin
          age_q[idx_q] <= '0;
          cnt_q[idx_q] <= (cur_cnt == lfu_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
          if (req_q.func == lfu_pkg::FUNC_PUT) begin
            value_q[idx_q] <= req_q.write_value;
          end
        end else if (cur_valid && (cur_age < hit_age_q)) begin
          age_q[idx_q] <= cur_age + 1'b1;
        end
      end else if (at_idx_ins) begin
        key_q[idx_q]   <= req_q.key;
        value_q[idx_q] <= req_q.write_value;
        cnt_q[idx_q]   <= lfu_pkg::CNT_W'(1);
        age_q[idx_q]   <= '0;
      end else if (cur_valid && !at_idx_vic) begin
        // ranks above the victim close the gap, then all age by one
        if (!(evict_q && (cur_age > vic_age_q))) begin
          age_q[idx_q] <= cur_age + 1'b1;
        end
      end
    end
  end

  // occupancy tracks the valid bits between requests
  a_occ_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match valid bits");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= lfu_pkg::OCC_W'(lfu_pkg::ENTRIES))
    else $error("occupancy above built size");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after accepting a request");

  // an insert without eviction must find a free slot
  a_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE && req_q.func == lfu_pkg::FUNC_PUT && !hit_q && !need_evict
    |-> free_found_q)
    else $error("insert with no free slot");

endmodule

@@ verif/lfu_checker.sv @@
// lfu cache scoreboard: keeps its own copy of the cache and checks each response word
module lfu_checker
  import lfu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  req_t             in_req_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  rsp_t             out_rsp_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int               errors_o,
  output int               pending_o
);

  logic [CAP_W-1:0]  capacity_q;
  bit                slot_used  [ENTRIES];
  logic [WORD_W-1:0] slot_key   [ENTRIES];
  logic [WORD_W-1:0] slot_value [ENTRIES];
  logic [CNT_W-1:0]  slot_uses  [ENTRIES];
  logic [AGE_W-1:0]  slot_rank  [ENTRIES];
  int unsigned       fill_level;
  rsp_t              awaited_rsp [$];
  rsp_t              oldest_rsp;

  // rank 0 is the most recently touched slot
  function automatic void make_newest(int unsigned i);
    logic [AGE_W-1:0] r;
    int j;
    r = slot_rank[i];
    for (j = 0; j < ENTRIES; j++) begin
      if (slot_used[j] && slot_rank[j] < r) slot_rank[j]++;
    end
    slot_rank[i] = '0;
  endfunction

  function automatic void count_use(int unsigned i);
    if (slot_uses[i] != COUNT_MAX) slot_uses[i]++;
    make_newest(i);
  endfunction

  // lowest use count, ties to the oldest rank
  function automatic int unsigned coldest_slot();
    int unsigned best;
    bit          have;
    int          j;
    best = 0;
    have = 1'b0;
    for (j = 0; j < ENTRIES; j++) begin
      if (slot_used[j] && (!have || slot_uses[j] < slot_uses[best] ||
          (slot_uses[j] == slot_uses[best] && slot_rank[j] > slot_rank[best]))) begin
        best = j;
        have = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic void evict_slot(int unsigned i);
    logic [AGE_W-1:0] r;
    int j;
    r = slot_rank[i];
    slot_used[i] = 1'b0;
    for (j = 0; j < ENTRIES; j++) begin
      if (slot_used[j] && slot_rank[j] > r) slot_rank[j]--;
    end
    if (fill_level > 0) fill_level--;
  endfunction

  function automatic rsp_t serve_request(req_t req);
    rsp_t        rsp;
    bit          hit;
    bit          placed;
    int unsigned where;
    int unsigned limit;
    int unsigned victim;
    int          j;
    int          k;
    rsp   = '0;
    hit   = 1'b0;
    where = 0;
    for (j = 0; j < ENTRIES; j++) begin
      if (!hit && slot_used[j] && slot_key[j] == req.key) begin
        hit   = 1'b1;
        where = j;
      end
    end
    rsp.found = hit;
    if (req.func == FUNC_GET) begin
      if (hit) begin
        rsp.read_value = slot_value[where];
        count_use(where);
      end else begin
        rsp.read_value = MISS_VALUE;
      end
    end else if (hit) begin
      slot_value[where] = req.write_value;
      count_use(where);
    end else begin
      limit = capacity_q;
      if (limit == 0) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      if (fill_level >= limit) begin
        victim          = coldest_slot();
        rsp.evicted     = 1'b1;
        rsp.evicted_key = slot_key[victim];
        evict_slot(victim);
      end
      placed = 1'b0;
      for (j = 0; j < ENTRIES; j++) begin
        if (!placed && !slot_used[j]) begin
          placed = 1'b1;
          for (k = 0; k < ENTRIES; k++) begin
            if (slot_used[k]) slot_rank[k]++;
          end
          slot_used[j]  = 1'b1;
          slot_key[j]   = req.key;
          slot_value[j] = req.write_value;
          slot_uses[j]  = CNT_W'(1);
          slot_rank[j]  = '0;
          fill_level++;
        end
      end
    end
    return rsp;
  endfunction

  task automatic flag(string msg);
    $display("%0t: %s", $time, msg);
    errors_o++;
  endtask

  task automatic compare_rsp(rsp_t want, rsp_t got);
    if (got.found !== want.found)
      flag($sformatf("found: expected %b, got %b", want.found, got.found));
    if (got.read_value !== want.read_value)
      flag($sformatf("read_value: expected %h, got %h", want.read_value, got.read_value));
    if (got.evicted !== want.evicted)
      flag($sformatf("evicted: expected %b, got %b", want.evicted, got.evicted));
    if (got.evicted_key !== want.evicted_key)
      flag($sformatf("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key));
  endtask

  // responses are checked before the request of the same edge is modeled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q = CAP_RESET;
      fill_level = 0;
      foreach (slot_used[j]) slot_used[j] = 1'b0;
      awaited_rsp.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          flag($sformatf("response %h with none awaited", out_rsp_i));
        end else begin
          oldest_rsp = awaited_rsp.pop_front();
          compare_rsp(oldest_rsp, out_rsp_i);
        end
      end
      if (in_valid_i && in_ready_i) awaited_rsp.push_back(serve_request(in_req_i));
      if (cfg_valid_i && cfg_ready_i) capacity_q = cfg_data_i;
      pending_o = awaited_rsp.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// top of the lfu cache testbench: clock, reset, stimulus, back-pressure and verdict
module testbench;
  import lfu_pkg::*;

  // about 820 requests, each possibly behind a sender gap and a receiver stall,
  // stay far below this limit
  localparam int unsigned RUN_LIMIT        = 2_000_000;
  // covers a whole put end to end, so nothing is still in flight
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned KEY_POOL_SIZE    = 24;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned PHASE_ITEMS      = 80;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  req_t             in_req;
  logic             out_valid;
  logic             out_ready;
  rsp_t             out_rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int               errors;
  int               pending;
  int unsigned      cycles;

  // handshakes between the stimulus and the receiver process
  bit               hold_off_req;
  bit               rx_steady;
  bit               tx_steady;

  logic [WORD_W-1:0] key_pool   [KEY_POOL_SIZE];
  logic [CAP_W-1:0]  phase_caps [PHASES];

  lfu_cache_with_lru_tiebreak dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  lfu_checker lfu_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one request word and hold it until the edge that takes it;
  // ready is sampled at the falling edge, where nothing is changing
  task automatic offer(logic func, logic [WORD_W-1:0] key, logic [WORD_W-1:0] value);
    bit taken;
    in_valid <= 1'b1;
    in_req   <= '{func: func, key: key, write_value: value};
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // sender idling: mostly back to back, sometimes a few cycles, rarely long
  task automatic sender_gap();
    int unsigned pick;
    int unsigned n;
    if (tx_steady) return;
    pick = $urandom_range(0, 99);
    if (pick < 60) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering until every response owed has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // capacity changes only with the cache idle
  task automatic set_capacity(logic [CAP_W-1:0] value);
    bit taken;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // random request over a key window a bit wider than the capacity, so hits,
  // misses and evictions all show up; now and then a fully random key
  task automatic offer_random(int unsigned span);
    logic              op;
    logic [WORD_W-1:0] key;
    op = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, span - 1)];
    else key = $urandom;
    sender_gap();
    offer(op ? FUNC_PUT : FUNC_GET, key, $urandom);
  endtask

  // receiver: random ready with short and long stalls, a fully ready mode, and
  // one long hold-off on request so the block backs up into its input
  initial begin
    int unsigned pick;
    int unsigned n;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
      end else if (rx_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 30);
        end else if (pick < 92) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(20, 80);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned span;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_off_req = 1'b0;
    rx_steady    = 1'b0;
    tx_steady    = 1'b0;

    // corner keys first, the rest random over the full word
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (i = 5; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // 31 and 17 exceed the built size, 0 acts as one entry; 31 follows a full
    // cache at 16 and 1 follows it, so capacity drops below occupancy
    phase_caps = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd4, 5'd8, 5'd3, 5'd0, 5'd5, 5'd16};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, two entries
    set_capacity(5'd2);
    // miss on an empty cache, write data ignored
    offer(FUNC_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    // extreme keys and values
    offer(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    offer(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    offer(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
    // full: the entry used once goes
    offer(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // a hit whose stored value looks like the miss marker
    offer(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    offer(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    // update in place
    offer(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    // new keys: the entry with the lowest count is the one evicted
    offer(FUNC_PUT, 32'd10, 32'd100);
    offer(FUNC_PUT, 32'd11, 32'd110);
    offer(FUNC_PUT, 32'd12, 32'd120);
    offer(FUNC_GET, 32'd11, 32'd0);
    offer(FUNC_GET, 32'd12, 32'd0);
    offer(FUNC_PUT, 32'd13, 32'd130);

    // zero capacity behaves as one entry
    set_capacity(5'd0);
    offer(FUNC_PUT, 32'd20, 32'd200);
    offer(FUNC_PUT, 32'd21, 32'd210);
    offer(FUNC_GET, 32'd20, 32'd0);
    offer(FUNC_GET, 32'd21, 32'd0);

    // ---- random phases, one capacity each
    for (p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      // one phase runs with the receiver always ready
      rx_steady = (p == 8);
      span = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p];
      span = span + 4;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // some stretches of twenty go without sender gaps
        if (i % 20 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        // receiver holds off while the sender keeps pushing
        if (p == 2 && i == 30) begin
          hold_off_req = 1'b1;
          tx_steady    = 1'b1;
        end
        // sender waits for every response before going on
        if (p == 5 && i == 40) drain();
        offer_random(span);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
